// ===== hw/rtl/lta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lta_pkg;

	// Field widths fixed by the item formats.
	localparam int SAMPLE_W = 24;
	localparam int LAYER_W  = 6;
	localparam int CFG_W    = 7;

	// Store widths: a 40-bit running sum and a 16-bit saturating count per layer.
	localparam int SUM_W = 40;
	localparam int CNT_W = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic [LAYER_W-1:0]         layer_index;
		logic                       value_missing;
		logic                       end_of_set;
	} in_item_t;

	typedef struct packed {
		logic [LAYER_W-1:0]         out_layer;
		logic signed [SAMPLE_W-1:0] layer_mean;
		logic                       layer_empty;
		logic                       last_layer;
	} out_item_t;

	// One word of the layer store.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
	} entry_t;

	localparam int ENTRY_W = SUM_W + CNT_W;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;        // latch the incoming item, read its layer
		logic acc_wr;      // write back the updated layer entry
		logic em_sel;      // address the store with the emission layer counter
		logic div_start;   // load the divider with the entry just read
		logic out_load;    // load the output register
		logic next_layer;  // advance the emission layer counter
		logic clear_all;   // drop every entry and rewind the layer counter
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic item_end;    // latched item carries the end-of-set mark
		logic last_layer;  // emission counter is at the final layer in use
		logic div_busy;    // divider is iterating
		logic out_free;    // output register can take a new result this cycle
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lta_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lta_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Signed-by-unsigned restoring divider, one quotient bit per cycle.
// The quotient is truncated toward zero.
module lta_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [lta_pkg::SUM_W-1:0]  dividend,
	input  wire logic        [lta_pkg::CNT_W-1:0]  divisor,
	output logic                                   busy,
	output logic signed      [lta_pkg::SUM_W-1:0]  quotient
);

	localparam int SW    = lta_pkg::SUM_W;
	localparam int CW    = lta_pkg::CNT_W;
	localparam int STEPW = $clog2(SW + 1);

	logic [SW-1:0]    quo_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    dvs_q;
	logic             neg_q;
	logic [STEPW-1:0] step_q;
	logic             busy_q;

	logic [CW:0]   shifted;
	logic [CW+1:0] diff;
	logic          fits;

	assign shifted = {rem_q, quo_q[SW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = ~diff[CW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEPW'(SW);
		end else if (busy_q) begin
			step_q <= step_q - STEPW'(1);
			if (step_q == STEPW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[SW-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[CW-1:0] : shifted[CW-1:0];
			quo_q <= {quo_q[SW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

// ===== hw/rtl/lta_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lta_dp #(
	parameter int MAX_LAYERS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lta_pkg::cmd_t                 cmd,
	output lta_pkg::sts_t                      sts,
	input  wire lta_pkg::in_item_t             sample,
	input  wire logic                          cfg_we,
	input  wire logic [lta_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          result_ready,
	output logic                               result_valid,
	output lta_pkg::out_item_t                 result
);

	localparam int AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int SW = lta_pkg::SUM_W;
	localparam int CW = lta_pkg::CNT_W;
	localparam int VW = lta_pkg::SAMPLE_W;
	localparam logic [lta_pkg::CFG_W-1:0] MAXL = lta_pkg::CFG_W'(MAX_LAYERS);

	logic [lta_pkg::CFG_W-1:0] cfg_q;
	logic [lta_pkg::CFG_W-1:0] n_eff;
	lta_pkg::in_item_t         item_q;
	logic [AW-1:0]             layer_q;
	logic [MAX_LAYERS-1:0]     vld_q;
	logic                      vld_s1;
	logic                      empty_q;
	lta_pkg::out_item_t        result_q;
	logic                      result_valid_q;

	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic [lta_pkg::ENTRY_W-1:0] rd_data;
	lta_pkg::entry_t             rd_entry;
	lta_pkg::entry_t             wr_entry;
	logic signed [SW-1:0]        cur_sum;
	logic [CW-1:0]               cur_cnt;
	logic                        acc_ok;
	logic                        wr_en;
	logic                        div_busy;
	logic signed [SW-1:0]        quotient;

	// Effective layer count: zero acts as one, anything above the store depth clamps.
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = lta_pkg::CFG_W'(1);
		end else if (cfg_q > MAXL) begin
			n_eff = MAXL;
		end else begin
			n_eff = cfg_q;
		end
	end

	assign rd_addr  = cmd.em_sel ? layer_q : sample.layer_index[AW-1:0];
	assign wr_addr  = item_q.layer_index[AW-1:0];
	assign rd_entry = lta_pkg::entry_t'(rd_data);
	assign cur_sum  = vld_s1 ? rd_entry.sum : '0;
	assign cur_cnt  = vld_s1 ? rd_entry.count : '0;

	assign acc_ok = ~item_q.value_missing
		&& ({1'b0, item_q.layer_index} < n_eff)
		&& (cur_cnt != lta_pkg::COUNT_MAX);
	assign wr_en  = cmd.acc_wr && acc_ok;

	always_comb begin
		wr_entry.sum   = cur_sum + {{(SW - VW){item_q.sample_value[VW-1]}}, item_q.sample_value};
		wr_entry.count = cur_cnt + CW'(1);
	end

	lta_ram #(
		.WIDTH(lta_pkg::ENTRY_W),
		.DEPTH(MAX_LAYERS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_entry),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	lta_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(cur_sum),
		.divisor (cur_cnt),
		.busy    (div_busy),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q          <= lta_pkg::CFG_RESET;
			layer_q        <= '0;
			vld_q          <= '0;
			vld_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (cmd.clear_all) begin
				layer_q <= '0;
				vld_q   <= '0;
			end else begin
				if (cmd.next_layer) begin
					layer_q <= layer_q + AW'(1);
				end
				if (wr_en) begin
					vld_q[wr_addr] <= 1'b1;
				end
			end
			vld_s1 <= vld_q[rd_addr];
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= sample;
		end
		if (cmd.div_start) begin
			empty_q <= (cur_cnt == '0);
		end
		if (cmd.out_load) begin
			result_q.out_layer   <= lta_pkg::LAYER_W'(layer_q);
			result_q.layer_mean  <= empty_q ? '0 : quotient[VW-1:0];
			result_q.layer_empty <= empty_q;
			result_q.last_layer  <= sts.last_layer;
		end
	end

	always_comb begin
		sts.item_end   = item_q.end_of_set;
		sts.last_layer = (lta_pkg::CFG_W'(layer_q) == n_eff - lta_pkg::CFG_W'(1));
		sts.div_busy   = div_busy;
		sts.out_free   = ~result_valid_q | result_ready;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lta_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lta_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           sample_valid,
	output logic                sample_ready,
	output lta_pkg::cmd_t       cmd,
	input  wire lta_pkg::sts_t  sts
);

	typedef enum logic [2:0] {
		IDLE,
		ACC,
		EM_RD,
		EM_LD,
		EM_DIV,
		EM_PUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_ready = 1'b0;
		case (state_q)
			IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.take = 1'b1;
					state_d  = ACC;
				end
			end
			ACC: begin
				cmd.acc_wr = 1'b1;
				state_d    = sts.item_end ? EM_RD : IDLE;
			end
			EM_RD: begin
				cmd.em_sel = 1'b1;
				state_d    = EM_LD;
			end
			EM_LD: begin
				cmd.div_start = 1'b1;
				state_d       = EM_DIV;
			end
			EM_DIV: begin
				if (!sts.div_busy) begin
					state_d = EM_PUT;
				end
			end
			EM_PUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last_layer) begin
						cmd.clear_all = 1'b1;
						state_d       = IDLE;
					end else begin
						cmd.next_layer = 1'b1;
						state_d        = EM_RD;
					end
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/layer_trend_average.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-layer mean of a stream of signed Q8.16 samples. Each sample item names
// its layer; defined samples for a layer below the configured layer count are
// added to that layer's 40-bit sum and 16-bit count (a full count ignores
// further samples). The item marked end of set is accumulated first, then one
// result item per layer in use is sent, layer 0 first, carrying the sum
// divided by the count truncated toward zero, or the empty flag with a zero
// mean. The store is then cleared. An ordinary sample item reads its layer's
// entry from the store (one read port, one write port) and then writes it back.
// After the end-of-set item is accumulated, each layer in use goes through a
// store read, a divider load, the 40 steps of the bit-serial divider plus
// handoff and an output load, longer while the sink holds results back.
// The last result may wait in the output register while the next sample is
// already being taken. The store is cleared at once after reset and after each
// set through per-layer valid flags, so there is no clearing pass.
// layers_in_use resets to 64; zero acts as one and values above MAX_LAYERS act
// as MAX_LAYERS. Write it only while the block is idle.
module layer_trend_average #(
	parameter int MAX_LAYERS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	// Sample channel.
	input  wire logic                         sample_valid,
	output logic                              sample_ready,
	input  wire lta_pkg::in_item_t            sample,

	// Result channel.
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output lta_pkg::out_item_t                result,

	// Configuration channel: writes layers_in_use.
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [lta_pkg::CFG_W-1:0]    cfg_data
);

	lta_pkg::cmd_t cmd;
	lta_pkg::sts_t sts;

	// The register can always be written; the user keeps writes to idle periods.
	assign cfg_ready = 1'b1;

	lta_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	lta_dp #(
		.MAX_LAYERS(MAX_LAYERS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.result_ready(result_ready),
		.result_valid(result_valid),
		.result      (result)
	);

	// A result is never loaded over one that the sink has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while the previous one is still pending");

	// Each accepted item is accumulated before another one is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> !sample_ready)
		else $error("sample taken during accumulation");

	// The store is cleared only together with the final result of a set.
	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |-> (cmd.out_load && sts.last_layer))
		else $error("store cleared before the final layer was sent");

	// The controller drives at most one datapath phase at a time.
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.acc_wr, cmd.em_sel, cmd.div_start, cmd.out_load}))
		else $error("overlapping datapath commands");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the per-layer mean block.
//
// The bench holds its own copy of the per-layer sums and counts and of the
// layer count register. Every sample item accepted on the input channel is
// folded into that copy. On the item that closes a set, the expected mean of
// every layer in use is queued, and the copy is cleared. Every result item
// taken from the block is compared, field by field, with the oldest queued
// mean. A handful of directed rows carry their expected results typed in
// directly, because those can be read off without any arithmetic.
module tb_top;
	import lta_pkg::*;

	localparam int LAYERS = 64;

	// Cycles of silence allowed after the last result before the block counts
	// as idle. This is well above the time that an ordinary sample item and
	// the hand-off of the output register take.
	localparam int QUIET_CYCLES = 50;

	// Emitting a layer runs the bit-serial divider, and a stalled sink adds more.
	// No correct run goes anywhere near this many cycles without a handshake.
	localparam int WATCHDOG_LIMIT = 5000;

	// Sample items sent by the random part. Together with the directed rows the
	// run sends about 400 sample items.
	localparam int RANDOM_ITEMS = 380;

	logic clk;
	logic arst_n = 1'b0;

	logic sample_valid = 1'b0;
	logic sample_ready;
	in_item_t sample = '0;

	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	// When set, neither the sender nor the sink idles.
	bit steady = 1'b0;

	int fail_count = 0;
	int idle_cycles = 0;

	// Our copy of the block's state.
	logic [CFG_W-1:0] layers_cfg = CFG_RESET;
	longint layer_sum [LAYERS];
	int unsigned layer_cnt [LAYERS];

	// Means still owed by the block, oldest first.
	out_item_t pending_means [$];

	// Results typed into the directed table for the next end-of-set item.
	out_item_t typed_means [$];

	typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [CFG_W-1:0] cfg;
		in_item_t         item;
		int               reps;
		int               n_want;
		out_item_t        want_a;
		out_item_t        want_b;
	} stim_row_t;

	stim_row_t directed_rows [$];

	layer_trend_average #(
		.MAX_LAYERS(LAYERS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The register value acts as 1 when it is zero and saturates at the layer
	// count of the block.
	function automatic int active_layers();
		if (layers_cfg == 0) begin
			return 1;
		end
		if (layers_cfg > LAYERS) begin
			return LAYERS;
		end
		return int'(layers_cfg);
	endfunction

	// Folds one accepted sample item into our copy of the store. On the end of a
	// set it queues the typed results if any wait, else one mean per layer in use,
	// and clears the whole store, also the layers above the current layer count.
	function automatic void fold_sample(in_item_t it);
		int n;
		out_item_t r;
		n = active_layers();
		if (!it.value_missing && int'(it.layer_index) < n &&
			layer_cnt[it.layer_index] < COUNT_MAX) begin
			layer_sum[it.layer_index] += longint'($signed(it.sample_value));
			layer_cnt[it.layer_index] += 1;
		end
		if (!it.end_of_set) begin
			return;
		end
		if (typed_means.size() != 0) begin
			while (typed_means.size() != 0) begin
				pending_means.push_back(typed_means.pop_front());
			end
		end else begin
			for (int k = 0; k < n; k++) begin
				r.out_layer = LAYER_W'(k);
				r.layer_empty = (layer_cnt[k] == 0);
				// Integer division of signed operands truncates toward zero.
				r.layer_mean = r.layer_empty ? '0 :
					SAMPLE_W'(layer_sum[k] / longint'(layer_cnt[k]));
				r.last_layer = (k == n - 1);
				pending_means.push_back(r);
			end
		end
		foreach (layer_sum[k]) begin
			layer_sum[k] = 0;
			layer_cnt[k] = 0;
		end
	endfunction

	function automatic in_item_t make_item(int value, int layer, bit missing, bit eos);
		in_item_t it;
		it.sample_value = SAMPLE_W'(value);
		it.layer_index = LAYER_W'(layer);
		it.value_missing = missing;
		it.end_of_set = eos;
		return it;
	endfunction

	function automatic void add_cfg(int value);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.cfg = CFG_W'(value);
		row.item = '0;
		row.reps = 0;
		row.n_want = 0;
		row.want_a = '0;
		row.want_b = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_sample(int value, int layer, bit missing, bit eos,
		int reps = 1);
		stim_row_t row;
		row.kind = ROW_SAMPLE;
		row.cfg = '0;
		row.item = make_item(value, layer, missing, eos);
		row.reps = reps;
		row.n_want = 0;
		row.want_a = '0;
		row.want_b = '0;
		directed_rows.push_back(row);
	endfunction

	// Attaches one typed result to the newest row of the table.
	function automatic void add_want(int layer, int mean, bit empty, bit last);
		out_item_t r;
		int i;
		i = directed_rows.size() - 1;
		r.out_layer = LAYER_W'(layer);
		r.layer_mean = SAMPLE_W'(mean);
		r.layer_empty = empty;
		r.last_layer = last;
		if (directed_rows[i].n_want == 0) begin
			directed_rows[i].want_a = r;
		end else begin
			directed_rows[i].want_b = r;
		end
		directed_rows[i].n_want++;
	endfunction

	// Picks a register value, with the extremes and the out-of-range values
	// well represented. Small counts dominate to keep the emission short.
	function automatic logic [CFG_W-1:0] pick_layers();
		case ($urandom_range(9))
			0: begin
				return '0;
			end
			1: begin
				return CFG_W'(1);
			end
			2: begin
				return CFG_W'(LAYERS);
			end
			3: begin
				return CFG_W'($urandom_range(127, LAYERS + 1));
			end
			4: begin
				return CFG_W'($urandom_range(LAYERS - 1, 9));
			end
			default: begin
				return CFG_W'($urandom_range(8, 1));
			end
		endcase
	endfunction

	// Offers one sample item and returns at the edge where it is taken. Valid is
	// left high, so that a following call can present the next item in the very
	// next cycle. Idle cycles are only inserted while steady is clear.
	task automatic push_sample(in_item_t it);
		if (!steady && $urandom_range(99) < 19) begin
			sample_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < 19);
		end
		sample_valid <= 1'b1;
		sample <= it;
		do begin
			@(posedge clk);
		end while (!sample_ready);
	endtask

	// Stops the sender and waits until every owed mean has arrived, then lets
	// the block run dry. The first edge lets our store catch up with the item
	// taken at the edge that we were called on.
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_means.size() != 0) begin
			@(posedge clk);
		end
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Writes the layer count. The extra edge lets our copy of the register take
	// the new value before anyone reads it.
	task automatic write_layers(logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// The sink holds results back at random, except in the steady stretch.
	always @(posedge clk) begin
		result_ready <= steady || ($urandom_range(99) >= 19);
	end

	// Tracks every handshake: updates our copy of the register and the store,
	// and checks each result against the oldest owed mean.
	always @(posedge clk) begin : watch_channels
		out_item_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				layers_cfg = cfg_data;
			end
			if (sample_valid && sample_ready) begin
				fold_sample(sample);
			end
			if (result_valid && result_ready) begin
				if (pending_means.size() == 0) begin
					$error("result item with no mean owed: out_layer %0d, layer_mean %0d",
						result.out_layer, $signed(result.layer_mean));
					fail_count++;
				end else begin
					want = pending_means.pop_front();
					if (result.out_layer !== want.out_layer) begin
						$error("out_layer: expected %0d, actual %0d",
							want.out_layer, result.out_layer);
						fail_count++;
					end
					if (result.layer_mean !== want.layer_mean) begin
						$error("layer_mean: expected %0d, actual %0d",
							$signed(want.layer_mean), $signed(result.layer_mean));
						fail_count++;
					end
					if (result.layer_empty !== want.layer_empty) begin
						$error("layer_empty: expected %0d, actual %0d",
							want.layer_empty, result.layer_empty);
						fail_count++;
					end
					if (result.last_layer !== want.last_layer) begin
						$error("last_layer: expected %0d, actual %0d",
							want.last_layer, result.last_layer);
						fail_count++;
					end
				end
			end
		end
	end

	// Ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int sent;
		int set_no;
		int len;
		int n;
		int lay;
		bit miss;
		logic [31:0] raw;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A set under the reset value of the register: 64 layers, with a missing
		// sample and samples on both end layers.
		add_sample(1000, 0, 1'b0, 1'b0);
		add_sample(-3, 63, 1'b0, 1'b0);
		add_sample(555, 5, 1'b1, 1'b0);
		add_sample(7, 2, 1'b0, 1'b1);

		// One layer in use: the extremes of the sample range come back unchanged.
		add_cfg(1);
		add_sample(8388607, 0, 1'b0, 1'b1);
		add_want(0, 8388607, 1'b0, 1'b1);
		add_sample(-8388608, 0, 1'b0, 1'b1);
		add_want(0, -8388608, 1'b0, 1'b1);

		// A missing value and a layer out of range both leave the layer empty.
		add_sample(1234, 0, 1'b1, 1'b1);
		add_want(0, 0, 1'b1, 1'b1);
		add_sample(5, 63, 1'b0, 1'b1);
		add_want(0, 0, 1'b1, 1'b1);

		// A register value of zero acts as one layer.
		add_cfg(0);
		add_sample(9, 1, 1'b0, 1'b1);
		add_want(0, 0, 1'b1, 1'b1);
		add_sample(-9, 0, 1'b0, 1'b1);
		add_want(0, -9, 1'b0, 1'b1);

		// Two layers. Layer 0 sums to -1 over two samples, whose mean truncates to
		// zero rather than rounding down; layer 1 sums to 5 over two.
		add_cfg(2);
		add_sample(3, 0, 1'b0, 1'b0);
		add_sample(-4, 0, 1'b0, 1'b0);
		add_sample(7, 1, 1'b0, 1'b0);
		add_sample(-2, 1, 1'b0, 1'b1);
		add_want(0, 0, 1'b0, 1'b0);
		add_want(1, 2, 1'b0, 1'b1);

		// A register value above the layer count saturates.
		add_cfg(127);
		add_sample(100, 63, 1'b0, 1'b0);
		add_sample(-1, 40, 1'b0, 1'b1);

		// The layer count drops in the middle of a set: layer 50 is not emitted,
		// and the empty set after it shows that it was cleared all the same.
		add_cfg(64);
		add_sample(11, 50, 1'b0, 1'b0);
		add_sample(22, 10, 1'b0, 1'b0);
		add_cfg(20);
		add_sample(3, 5, 1'b0, 1'b1);
		add_cfg(64);
		add_sample(0, 0, 1'b1, 1'b1);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				settle();
				write_layers(directed_rows[i].cfg);
			end else begin
				// Typed rows wait for the block to drain, so that the typed
				// results can only belong to this row.
				if (directed_rows[i].n_want > 0) begin
					settle();
					typed_means.push_back(directed_rows[i].want_a);
					if (directed_rows[i].n_want > 1) begin
						typed_means.push_back(directed_rows[i].want_b);
					end
				end
				repeat (directed_rows[i].reps) begin
					push_sample(directed_rows[i].item);
				end
			end
		end

		// Random sets. Most samples land on a layer in use; the rest are missing
		// or aimed at any layer. The register changes between sets now and then,
		// and occasionally halfway through a set. Sets 20 to 31 run without any
		// idling on either side.
		sent = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (set_no >= 20 && set_no < 32);
			if (set_no % 8 == 0 || $urandom_range(4) == 0) begin
				settle();
				write_layers(pick_layers());
			end
			len = $urandom_range(12, 1);
			for (int j = 0; j < len; j++) begin
				if (j == len / 2 && j > 0 && $urandom_range(9) == 0) begin
					settle();
					write_layers(pick_layers());
				end
				n = active_layers();
				miss = ($urandom_range(9) == 0);
				if ($urandom_range(99) < 85) begin
					lay = int'($urandom_range(n - 1, 0));
				end else begin
					lay = int'($urandom_range(LAYERS - 1, 0));
				end
				case ($urandom_range(7))
					0: begin
						raw = 32'h007F_FFFF;
					end
					1: begin
						raw = 32'h0080_0000;
					end
					default: begin
						raw = $urandom;
					end
				endcase
				sent++;
				push_sample(make_item(int'(raw), lay, miss, j == len - 1));
			end
			set_no++;
		end
		steady = 1'b0;

		// Wait for every owed mean, then give the block time to send anything
		// it should not.
		settle();
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== layer_trend_average.f =====
hw/rtl/lta_pkg.sv
hw/rtl/lta_ram.sv
hw/rtl/lta_div.sv
hw/rtl/lta_dp.sv
hw/rtl/lta_ctrl.sv
hw/rtl/layer_trend_average.sv
tb/tb_top.sv
